/* design/grls_pkg.sv */
// ----------------------------------------------------------------------------
// Runway scheduler package
// Shared widths, transfer types, register map and the wake separation table.
// ----------------------------------------------------------------------------
`default_nettype none

package grls_pkg;

	localparam int CATS       = 4;
	localparam int CAT_W      = 2;
	localparam int TIME_W     = 24;
	localparam int WEIGHT_W   = 16;
	localparam int COST_W     = TIME_W + WEIGHT_W;
	localparam int TOTAL_W    = 48;
	localparam int RW_CNT_W   = 3;
	localparam int RUNWAY_W   = 2;
	localparam int SEP_W      = 8;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register index, taken from the word address bit of paddr.
	localparam logic REG_RUNWAYS_IN_USE = 1'b0;

	localparam logic [CAT_W-1:0] CAT_HEAVY  = 2'd0;
	localparam logic [CAT_W-1:0] CAT_MEDIUM = 2'd1;
	localparam logic [CAT_W-1:0] CAT_LIGHT  = 2'd2;
	localparam logic [CAT_W-1:0] CAT_OTHER  = 2'd3;

	typedef struct packed {
		logic                new_sequence;
		logic [CAT_W-1:0]    wake_category;
		logic [TIME_W-1:0]   target_time;
		logic [WEIGHT_W-1:0] penalty_weight;
	} item_t;

	typedef struct packed {
		logic [RUNWAY_W-1:0] assigned_runway;
		logic [TIME_W-1:0]   landing_time;
		logic [COST_W-1:0]   aircraft_cost;
		logic [TOTAL_W-1:0]  total_cost;
		logic                time_overflow;
	} result_t;

	// Outcome of placing the current aircraft on one runway.
	typedef struct packed {
		logic              ovf;
		logic [TIME_W-1:0] landing_time;
		logic [COST_W-1:0] cost;
	} eval_t;

	typedef struct packed {
		logic                en;
		logic                clear;
		logic [RW_CNT_W-1:0] runway;
		logic [CAT_W-1:0]    cat;
		logic [TIME_W-1:0]   landing_time;
	} hist_upd_t;

	// Wake separation in seconds from the leading aircraft's category to the
	// following one's.
	function automatic logic [SEP_W-1:0] sep_sec(input logic [CAT_W-1:0] lead,
			input logic [CAT_W-1:0] follow);
		logic [SEP_W-1:0] sep;
		sep = 8'd60;
		case (lead)
			CAT_HEAVY: begin
				case (follow)
					CAT_HEAVY:  sep = 8'd90;
					CAT_MEDIUM: sep = 8'd120;
					CAT_LIGHT:  sep = 8'd150;
					default:    sep = 8'd60;
				endcase
			end
			CAT_MEDIUM: begin
				case (follow)
					CAT_HEAVY:  sep = 8'd60;
					CAT_MEDIUM: sep = 8'd80;
					CAT_LIGHT:  sep = 8'd100;
					default:    sep = 8'd60;
				endcase
			end
			default: sep = 8'd60;
		endcase
		return sep;
	endfunction

endpackage

`default_nettype wire

/* design/grls_runway_eval.sv */
// ----------------------------------------------------------------------------
// Runway evaluation
// Release time, saturated landing time and delay cost for one runway.
// ----------------------------------------------------------------------------
`default_nettype none

module grls_runway_eval (
	input  logic [grls_pkg::CAT_W-1:0]                        cat,
	input  logic [grls_pkg::TIME_W-1:0]                       target,
	input  logic [grls_pkg::WEIGHT_W-1:0]                     weight,
	input  logic [grls_pkg::CATS-1:0][grls_pkg::TIME_W-1:0]   latest,
	input  logic [grls_pkg::CATS-1:0]                         seen,
	output grls_pkg::eval_t                                   res
);
	import grls_pkg::*;

	localparam int TW1 = TIME_W + 1;

	logic [TIME_W:0]   cand;
	logic [TIME_W:0]   rel_time;
	logic [TIME_W:0]   t_full;
	logic [TIME_W-1:0] t_sat;
	logic [TIME_W-1:0] delay;

	always_comb begin
		rel_time = '0;
		cand     = '0;
		for (int c = 0; c < CATS; c++) begin
			cand = {1'b0, latest[c]} + TW1'(sep_sec(CAT_W'(c), cat));
			if (seen[c] && (cand > rel_time)) begin
				rel_time = cand;
			end
		end
	end

	assign t_full = (rel_time > {1'b0, target}) ? rel_time : {1'b0, target};
	assign t_sat  = t_full[TIME_W] ? {TIME_W{1'b1}} : t_full[TIME_W-1:0];
	assign delay  = t_sat - target;

	assign res.ovf          = t_full[TIME_W];
	assign res.landing_time = t_sat;
	assign res.cost         = COST_W'(delay) * COST_W'(weight);

endmodule

`default_nettype wire

/* design/grls_history.sv */
// ----------------------------------------------------------------------------
// Runway history
// Latest landing time per runway and wake category, with a seen flag each.
// ----------------------------------------------------------------------------
`default_nettype none

module grls_history #(
	parameter int MAX_RUNWAYS = 4
) (
	input  logic                                                         clk,
	input  logic                                                         arst_n,
	input  grls_pkg::hist_upd_t                                          upd,
	output logic [MAX_RUNWAYS*grls_pkg::CATS-1:0][grls_pkg::TIME_W-1:0]  latest,
	output logic [MAX_RUNWAYS*grls_pkg::CATS-1:0]                        seen
);
	import grls_pkg::*;

	localparam int SLOTS = MAX_RUNWAYS * CATS;

	logic [SLOTS-1:0][TIME_W-1:0] latest_q;
	logic [SLOTS-1:0]             seen_q;
	logic [SLOTS-1:0]             hit;
	logic [SLOTS-1:0]             wr;

	always_comb begin
		hit = '0;
		wr  = '0;
		for (int r = 0; r < MAX_RUNWAYS; r++) begin
			for (int c = 0; c < CATS; c++) begin
				hit[r*CATS+c] = (RW_CNT_W'(r) == upd.runway) && (CAT_W'(c) == upd.cat);
				// A slot cleared by a new sequence counts as empty.
				wr[r*CATS+c]  = hit[r*CATS+c] && ((seen_q[r*CATS+c] && !upd.clear) ?
					(upd.landing_time > latest_q[r*CATS+c]) : 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (upd.en) begin
			seen_q <= hit | (seen_q & ~{SLOTS{upd.clear}});
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			for (int s = 0; s < SLOTS; s++) begin
				if (wr[s]) begin
					latest_q[s] <= upd.landing_time;
				end
			end
		end
	end

	assign latest = latest_q;
	assign seen   = seen_q;

endmodule

`default_nettype wire

/* design/grls_select.sv */
// ----------------------------------------------------------------------------
// Runway selection
// Picks the runway with the least cost, then earliest time, then lowest index.
// ----------------------------------------------------------------------------
`default_nettype none

module grls_select #(
	parameter int MAX_RUNWAYS = 4
) (
	input  grls_pkg::eval_t [MAX_RUNWAYS-1:0]    evals,
	input  logic [grls_pkg::RW_CNT_W-1:0]         runways_in_use,
	output grls_pkg::eval_t                       best,
	output logic [grls_pkg::RW_CNT_W-1:0]         best_rw
);
	import grls_pkg::*;

	// Runway 0 is always considered, so a count of zero behaves as one and
	// counts above the runway total stop at the last runway.
	always_comb begin
		best    = evals[0];
		best_rw = '0;
		for (int r = 1; r < MAX_RUNWAYS; r++) begin
			if ((RW_CNT_W'(r) < runways_in_use) &&
					((evals[r].cost < best.cost) ||
					((evals[r].cost == best.cost) &&
					(evals[r].landing_time < best.landing_time)))) begin
				best    = evals[r];
				best_rw = RW_CNT_W'(r);
			end
		end
	end

endmodule

`default_nettype wire

/* design/greedy_runway_landing_scheduler.sv */
// ----------------------------------------------------------------------------
// Greedy runway landing scheduler
// Assigns each aircraft to the runway of least delay cost and keeps a
// saturating running total of cost per sequence.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Role
//  item      item_valid, item_ready, item_data         aircraft in, valid/ready
//  result    result_valid, result_ready, result_data   assignment out, valid/ready
//  config    psel, penable, pwrite, paddr, pwdata,     APB register access,
//            prdata, pready                            runways_in_use at 0x0
//
// An aircraft is registered on acceptance and evaluated against all runways in
// the following cycle; its result is loaded into the output register when that
// register is empty or being drained. One aircraft is taken every cycle while
// results are drained; the history update closes within the evaluation cycle,
// which sets the rate.
// Reset clears the seen flags, the running total and the valid flags, and sets
// runways_in_use to one. A stalled result holds the output register and the
// input register; the input stays ready while the input register is free.
//
`default_nettype none

module greedy_runway_landing_scheduler #(
	parameter int MAX_RUNWAYS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [grls_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [grls_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [grls_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  grls_pkg::item_t                   item_data,
	output logic                              result_valid,
	input  logic                              result_ready,
	output grls_pkg::result_t                 result_data
);
	import grls_pkg::*;

	localparam int SLOTS = MAX_RUNWAYS * CATS;

	logic [RW_CNT_W-1:0]          runways_q;
	logic                         reg_sel;
	logic                         cfg_wr;

	item_t                        item_s1;
	logic                         valid_s1;
	logic                         advance;
	logic                         fire;

	result_t                      result_q;
	logic                         result_valid_q;
	logic [TOTAL_W-1:0]           total_q;
	logic [TOTAL_W-1:0]           total_base;
	logic [TOTAL_W:0]             total_sum;
	logic [TOTAL_W-1:0]           total_next;

	logic [SLOTS-1:0][TIME_W-1:0] latest;
	logic [SLOTS-1:0]             seen;
	logic [SLOTS-1:0]             seen_eff;
	eval_t [MAX_RUNWAYS-1:0]      evals;
	eval_t                        best;
	logic [RW_CNT_W-1:0]          best_rw;
	hist_upd_t                    upd;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_RUNWAYS_IN_USE);
	assign cfg_wr  = psel && penable && pwrite && reg_sel;
	assign prdata  = reg_sel ? APB_DATA_W'(runways_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runways_q <= RW_CNT_W'(1);
		end else if (cfg_wr) begin
			runways_q <= pwdata[RW_CNT_W-1:0];
		end
	end

	// Handshake: the evaluation stage moves whenever the output register
	// is empty or being drained.
	assign advance    = !result_valid_q || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign fire       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item_data;
		end
	end

	// Evaluation
	grls_history #(
		.MAX_RUNWAYS(MAX_RUNWAYS)
	) u_history (
		.clk   (clk),
		.arst_n(arst_n),
		.upd   (upd),
		.latest(latest),
		.seen  (seen)
	);

	assign seen_eff = seen & ~{SLOTS{item_s1.new_sequence}};

	for (genvar r = 0; r < MAX_RUNWAYS; r++) begin : g_runway
		grls_runway_eval u_eval (
			.cat   (item_s1.wake_category),
			.target(item_s1.target_time),
			.weight(item_s1.penalty_weight),
			.latest(latest[r*CATS +: CATS]),
			.seen  (seen_eff[r*CATS +: CATS]),
			.res   (evals[r])
		);
	end

	grls_select #(
		.MAX_RUNWAYS(MAX_RUNWAYS)
	) u_select (
		.evals         (evals),
		.runways_in_use(runways_q),
		.best          (best),
		.best_rw       (best_rw)
	);

	always_comb begin
		upd.en           = fire;
		upd.clear        = item_s1.new_sequence;
		upd.runway       = best_rw;
		upd.cat          = item_s1.wake_category;
		upd.landing_time = best.landing_time;
	end

	// Running total, restarted by a new sequence and held at its maximum.
	assign total_base = item_s1.new_sequence ? '0 : total_q;
	assign total_sum  = {1'b0, total_base} + (TOTAL_W+1)'(best.cost);
	assign total_next = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (fire) begin
			total_q <= total_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.assigned_runway <= best_rw[RUNWAY_W-1:0];
			result_q.landing_time    <= best.landing_time;
			result_q.aircraft_cost   <= best.cost;
			result_q.total_cost      <= total_next;
			result_q.time_overflow   <= best.ovf;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

`default_nettype wire

/* design/grls_checker.sv */
// ----------------------------------------------------------------------------
// Runway scheduler checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module grls_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input grls_pkg::result_t result_data
);
	import grls_pkg::*;

	// A result waiting for the consumer stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result withdrawn while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_data))
		else $error("result payload changed while stalled");

	// An overflowed landing time must read as the saturated maximum.
	a_overflow_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.time_overflow |->
		result_data.landing_time == {TIME_W{1'b1}})
		else $error("overflow flagged without saturated landing time");

	// The running total always includes the current aircraft's cost.
	a_total_covers: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.total_cost >= TOTAL_W'(result_data.aircraft_cost))
		else $error("running total below aircraft cost");

	// From an empty output, a result appears after a transfer has passed the input register and the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready, 2))
		else $error("result without a matching input transfer");

endmodule

bind greedy_runway_landing_scheduler grls_checker u_grls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result_data (result_data)
);

`default_nettype wire
